[rtl/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] request_bytes;
        logic [31:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] payload_address;
        logic [1:0]  status;
    } t_out_item;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_OOM     = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic CFG_REGION_LOWER = 1'b0;
    localparam logic CFG_REGION_UPPER = 1'b1;

    // One table entry: header address, payload size and free mark.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_REQ,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_NBR_RD,
        S_NBR_CHK,
        S_DROP_RD,
        S_DROP_WR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/ffha_table.sv]
`default_nettype none
// Block table memory: one write port, one registered read port.
module ffha_table #(
    parameter int AW = 6
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  ffha_pkg::t_entry    i_wdata,
    input  wire [AW-1:0]        i_raddr,
    output ffha_pkg::t_entry    o_rdata
);
    ffha_pkg::t_entry r_mem [2**AW];
    ffha_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/first_fit_heap_allocator_core.sv]
`default_nettype none
// First-fit heap allocator. The managed region lives in a table of up to
// MAX_BLOCKS address-ordered entries held in one synchronous memory. An
// allocate beat scans entries one at a time, a read and a check each,
// until the first free entry that fits, then, if it splits, moves every
// later entry up by one, a read and a write per entry. A free beat scans
// for its entry, then merges free neighbors, closing each gap by moving
// later entries down, a read and a write per entry. Every scan step and
// table move goes through the one table memory. Entry 0 is rebuilt
// directly on reset or on a region write, so no clearing pass is needed.
// The result waits in an output register; the next input beat is taken
// once that result has been taken.
module first_fit_heap_allocator_core #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  ffha_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  wire                 i_stall,
    output ffha_pkg::t_out_item o_data,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_index,
    input  wire [31:0]          i_cfg_data
);
    localparam int AW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    ffha_pkg::t_state r_state, n_state;
    logic [31:0] r_lower, r_upper;
    logic        r_rebuild;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;   // entry of interest
    logic [AW-1:0] r_ptr, n_ptr;   // move pointer
    ffha_pkg::t_in_item r_in;
    ffha_pkg::t_entry   r_cur, n_cur;  // entry being allocated/freed
    logic [32:0] r_need;
    logic        r_dir, n_dir;   // 0 merge left pending, 1 merge right
    logic        r_ov, n_ov;
    ffha_pkg::t_out_item r_out, n_out;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    ffha_pkg::t_entry wdata, rdata;

    ffha_table #(.AW(AW)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // Rebuild of entry 0 from the region registers.
    logic [31:0] lo_al;
    logic [32:0] need0;
    assign lo_al = (r_lower + 32'd3) & ~32'd3;
    assign need0 = {1'b0, lo_al} + {1'b0, HDR};

    logic        accept;
    logic [32:0] req_n;
    logic [31:0] rem;
    logic        fits, match, split;
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != ffha_pkg::S_IDLE) || r_rebuild || r_ov;
    assign o_valid = r_ov;
    assign o_data = r_out;
    assign req_n = ({1'b0, i_data.request_bytes} + 33'd3) & ~33'd3;
    assign fits = rdata.free && ({1'b0, rdata.size} >= r_need);
    assign match = !rdata.free && (rdata.start + HDR == r_in.release_address);
    // The remainder is split off only when it holds a header and more than a word.
    assign split = ({1'b0, rdata.size - r_need[31:0]} > 33'(HEADER_BYTES + 4))
                   && (r_count < MAXC);
    // Remainder of the granted entry, whose original size stays in r_cur.
    assign rem = r_cur.size - r_need[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
            r_lower <= 32'd0;
            r_upper <= 32'd65536;
            r_rebuild <= 1'b1;
            r_count <= CW'(1);
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov <= n_ov;
            r_rebuild <= 1'b0;
            if (i_cfg_we) begin
                r_rebuild <= 1'b1;
                unique case (i_cfg_index)
                    ffha_pkg::CFG_REGION_LOWER: r_lower <= i_cfg_data;
                    ffha_pkg::CFG_REGION_UPPER: r_upper <= i_cfg_data;
                endcase
            end
            if (r_rebuild) begin
                r_count <= CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_ptr <= n_ptr;
        r_cur <= n_cur;
        r_dir <= n_dir;
        r_out <= n_out;
        if (accept) begin
            r_in <= i_data;
            r_need <= req_n;
        end
    end

    // Neighbor address: left is idx-1, right is idx+1.
    logic          nbr_exists;
    logic [AW-1:0] nbr_addr;
    logic [AW-1:0] drop_pos;
    always_comb begin
        if (!r_dir) begin
            nbr_exists = (r_idx != '0);
            nbr_addr = r_idx - 1'b1;
            drop_pos = r_idx;
        end else begin
            nbr_exists = ({1'b0, r_idx} + 1'b1 < r_count);
            nbr_addr = r_idx + 1'b1;
            drop_pos = r_idx + 1'b1;
        end
    end

    // Neighbor step: merge, then drop or reread; else try right; else finish.
    function automatic ffha_pkg::t_state n_state_nbr();
        ffha_pkg::t_state s;
        s = ffha_pkg::S_DONE;
        if (nbr_exists && rdata.free) begin
            if ({1'b0, drop_pos} + 1'b1 >= r_count) s = ffha_pkg::S_NBR_RD;
            else s = ffha_pkg::S_DROP_RD;
        end else if (!r_dir) begin
            s = ffha_pkg::S_NBR_RD;
        end
        return s;
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_data.mode == ffha_pkg::MODE_ALLOC && i_data.request_bytes == 32'd0)
                        n_state = ffha_pkg::S_DONE;
                    else
                        n_state = ffha_pkg::S_SCAN_REQ;
                end
            end
            ffha_pkg::S_SCAN_REQ: n_state = ffha_pkg::S_SCAN_CHK;
            ffha_pkg::S_SCAN_CHK: begin
                if (r_in.mode == ffha_pkg::MODE_ALLOC ? fits : match) begin
                    if (r_in.mode == ffha_pkg::MODE_FREE)
                        n_state = ffha_pkg::S_NBR_RD;
                    else if (split)
                        n_state = ffha_pkg::S_SHIFT_RD;
                    else
                        n_state = ffha_pkg::S_DONE;
                end else if ({1'b0, r_idx} + 1'b1 >= r_count) begin
                    n_state = ffha_pkg::S_DONE;
                end else begin
                    n_state = ffha_pkg::S_SCAN_REQ;
                end
            end
            ffha_pkg::S_SHIFT_RD: n_state = ffha_pkg::S_SHIFT_WR;
            ffha_pkg::S_SHIFT_WR: begin
                if ({1'b0, r_ptr} <= {1'b0, r_idx} + 1'b1) n_state = ffha_pkg::S_DONE;
                else n_state = ffha_pkg::S_SHIFT_RD;
            end
            ffha_pkg::S_NBR_RD: n_state = ffha_pkg::S_NBR_CHK;
            ffha_pkg::S_NBR_CHK: n_state = n_state_nbr();
            ffha_pkg::S_DROP_RD: n_state = ffha_pkg::S_DROP_WR;
            ffha_pkg::S_DROP_WR: begin
                if ({1'b0, r_ptr} + 2'd2 >= r_count) n_state = ffha_pkg::S_NBR_RD;
                else n_state = ffha_pkg::S_DROP_RD;
            end
            ffha_pkg::S_DONE: n_state = ffha_pkg::S_IDLE;
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_count = r_count;
        n_idx = r_idx;
        n_ptr = r_ptr;
        n_cur = r_cur;
        n_dir = r_dir;
        n_ov = r_ov && i_stall;
        n_out = r_out;
        we = 1'b0;
        waddr = r_idx;
        wdata = r_cur;
        raddr = r_idx;
        if (r_rebuild) begin
            we = 1'b1;
            waddr = '0;
            wdata.start = lo_al;
            wdata.size = ({1'b0, r_upper} >= need0) ? 32'({1'b0, r_upper} - need0) : 32'd0;
            wdata.free = 1'b1;
        end
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                n_idx = '0;
                n_dir = 1'b0;
                if (accept) begin
                    n_out.payload_address = 32'd0;
                    n_out.status = ffha_pkg::ST_OK;
                    if (i_data.mode == ffha_pkg::MODE_ALLOC && i_data.request_bytes == 32'd0)
                        n_out.status = ffha_pkg::ST_ZERO;
                end
            end
            ffha_pkg::S_SCAN_REQ: raddr = r_idx;
            ffha_pkg::S_SCAN_CHK: begin
                n_cur = rdata;
                if (r_in.mode == ffha_pkg::MODE_ALLOC ? fits : match) begin
                    if (r_in.mode == ffha_pkg::MODE_ALLOC)
                        n_out.payload_address = rdata.start + HDR;
                    n_ptr = r_count[AW-1:0];
                    if (r_in.mode == ffha_pkg::MODE_ALLOC) begin
                        n_cur.free = 1'b0;
                        we = 1'b1;
                        waddr = r_idx;
                        wdata = n_cur;
                        // No split: the whole entry is granted and the table stays.
                        if (!split) begin
                            n_ptr = r_idx;
                        end else begin
                            wdata.size = r_need[31:0];
                        end
                    end else begin
                        n_cur.free = 1'b1;
                        we = 1'b1;
                        waddr = r_idx;
                        wdata = n_cur;
                    end
                end else if ({1'b0, r_idx} + 1'b1 >= r_count) begin
                    n_out.status = (r_in.mode == ffha_pkg::MODE_ALLOC)
                        ? ffha_pkg::ST_OOM : ffha_pkg::ST_UNKNOWN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ffha_pkg::S_SHIFT_RD: begin
                // r_ptr is the destination; ptr == idx+1 writes the new free block.
                raddr = r_ptr - 1'b1;
            end
            ffha_pkg::S_SHIFT_WR: begin
                we = 1'b1;
                waddr = r_ptr;
                wdata = rdata;
                if ({1'b0, r_ptr} <= {1'b0, r_idx} + 1'b1) begin
                    wdata.start = r_cur.start + HDR + r_need[31:0];
                    wdata.size = rem - HDR;
                    wdata.free = 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            ffha_pkg::S_NBR_RD: raddr = nbr_addr;
            ffha_pkg::S_NBR_CHK: begin
                if (nbr_exists && rdata.free) begin
                    // Merge into the lower entry of the pair.
                    we = 1'b1;
                    if (!r_dir) begin
                        n_cur.start = rdata.start;
                        n_cur.size = rdata.size + HDR + r_cur.size;
                        waddr = nbr_addr;
                        n_idx = nbr_addr;
                    end else begin
                        n_cur.size = r_cur.size + HDR + rdata.size;
                        waddr = r_idx;
                    end
                    n_cur.free = 1'b1;
                    wdata = n_cur;
                    n_ptr = drop_pos;
                    if ({1'b0, drop_pos} + 1'b1 >= r_count) n_count = r_count - 1'b1;
                end else begin
                    n_dir = 1'b1;
                end
            end
            ffha_pkg::S_DROP_RD: raddr = r_ptr + 1'b1;
            ffha_pkg::S_DROP_WR: begin
                we = 1'b1;
                waddr = r_ptr;
                wdata = rdata;
                n_ptr = r_ptr + 1'b1;
                if ({1'b0, r_ptr} + 2'd2 >= r_count) n_count = r_count - 1'b1;
            end
            ffha_pkg::S_DONE: n_ov = 1'b1;
            default: ;
        endcase
    end

    // The table never holds fewer than one or more than MAX_BLOCKS entries.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= MAXC))
        else $error("block count out of range");

    // A result appears only after the work of a beat ends.
    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ffha_pkg::S_DONE))
        else $error("result without finished beat");

    // No new beat is taken while a result waits.
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("beat taken with result pending");

endmodule
`default_nettype wire
